@@ design/trc_pkg.sv @@
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types and constants of the timestamp rate calibrator.
// ----------------------------------------------------------------------------
package trc_pkg;

   localparam int unsigned PROD_W = 88;   // delta (64) * ref_freq_hz (24)
   localparam int unsigned DIV_W  = 36;   // ticks (16) * 1e6 (20)

   localparam logic [15:0] FULL_COUNT = 16'hFFFF;
   localparam logic [19:0] US_PER_S   = 20'd1000000;

   // register indexes on the csr port
   localparam logic [2:0] CSR_WINDOW_END = 3'd0;
   localparam logic [2:0] CSR_REF_FREQ   = 3'd1;
   localparam logic [2:0] CSR_MIN_RATIO  = 3'd2;
   localparam logic [2:0] CSR_MAX_RATIO  = 3'd3;
   localparam logic [2:0] CSR_MAX_ATT    = 3'd4;
   localparam logic [2:0] CSR_FALLBACK   = 3'd5;

   typedef enum logic [2:0] {
      ST_ARMED    = 3'd0,
      ST_WRAP     = 3'd1,
      ST_IMPL     = 3'd2,
      ST_DONE     = 3'd3,
      ST_FALLBACK = 3'd4
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] ratio;
      logic [3:0]  attempt;
      logic        reload;
   } rsp_type;

   // result handed from the ratio unit to the controller
   typedef struct packed {
      logic        done;
      logic        ok;
      logic [15:0] ratio;
   } ratio_result_type;

endpackage

@@ design/trc_ratio_unit.sv @@
// ----------------------------------------------------------------------------
// trc_ratio_unit
// Computes floor(delta * freq / (ticks * 1e6)) with one shared 89-bit
// add/subtract unit: four 16x24 multiply-accumulate steps, then a 17-step
// restoring divide. The first divide step flags a quotient above 16 bits.
// ----------------------------------------------------------------------------
module trc_ratio_unit
   import trc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [63:0]      delta,
   input  logic [23:0]      freq,
   input  logic [15:0]      ticks,
   output ratio_result_type result
);

   typedef enum logic [2:0] {
      U_IDLE = 3'b001,
      U_MUL  = 3'b010,
      U_DIV  = 3'b100
   } unit_state_type;

   unit_state_type    state_ff, state_in;
   logic [63:0]       delta_ff, delta_in;
   logic [23:0]       freq_ff, freq_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [1:0]        k_ff, k_in;
   logic [4:0]        step_ff, step_in;
   logic [15:0]       q_ff, q_in;
   logic              done_ff, done_in;
   logic              ok_ff, ok_in;

   logic [39:0]       partial;
   logic [PROD_W-1:0] mul_term;
   logic [PROD_W-1:0] div_term;
   logic [PROD_W-1:0] opb;
   logic              sub;
   logic [PROD_W:0]   sum;
   logic              ge;

   // shared adder: accumulate partial products, or trial-subtract the divisor
   always_comb begin
      partial  = delta_ff[15:0] * freq_ff;
      mul_term = {48'b0, partial} << {k_ff, 4'b0000};
      div_term = {{(PROD_W-DIV_W){1'b0}}, div_ff} << step_ff;
      sub      = (state_ff == U_DIV);
      opb      = sub ? div_term : mul_term;
      sum      = {1'b0, acc_ff} + (sub ? ~{1'b0, opb} : {1'b0, opb})
                 + {{PROD_W{1'b0}}, sub};
      ge       = ~sum[PROD_W];
   end

   always_comb begin
      state_in = state_ff;
      delta_in = delta_ff;
      freq_in  = freq_ff;
      div_in   = div_ff;
      acc_in   = acc_ff;
      k_in     = k_ff;
      step_in  = step_ff;
      q_in     = q_ff;
      done_in  = 1'b0;
      ok_in    = ok_ff;
      if (start) begin
         delta_in = delta;
         freq_in  = freq;
         div_in   = {20'b0, ticks} * {16'b0, US_PER_S};
         acc_in   = '0;
         k_in     = 2'd0;
         state_in = U_MUL;
      end else begin
         unique case (state_ff)
            U_MUL: begin
               acc_in   = sum[PROD_W-1:0];
               delta_in = delta_ff >> 16;
               k_in     = k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  state_in = U_DIV;
                  step_in  = 5'd16;
                  q_in     = '0;
               end
            end
            U_DIV: begin
               if (ge) acc_in = sum[PROD_W-1:0];
               if (step_ff == 5'd16) begin
                  // quotient would need 17 bits; zero ticks lands here too
                  if (ge) begin
                     done_in  = 1'b1;
                     ok_in    = 1'b0;
                     state_in = U_IDLE;
                  end else begin
                     step_in = 5'd15;
                  end
               end else begin
                  q_in = {q_ff[14:0], ge};
                  if (step_ff == 5'd0) begin
                     done_in  = 1'b1;
                     ok_in    = 1'b1;
                     state_in = U_IDLE;
                  end else begin
                     step_in = step_ff - 5'd1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      delta_ff <= delta_in;
      freq_ff  <= freq_in;
      div_ff   <= div_in;
      acc_ff   <= acc_in;
      k_ff     <= k_in;
      step_ff  <= step_in;
      q_ff     <= q_in;
      ok_ff    <= ok_in;
   end

   assign result.done  = done_ff;
   assign result.ok    = ok_ff;
   assign result.ratio = q_ff;

endmodule

@@ design/timestamp_rate_calibrator_core.sv @@
// ----------------------------------------------------------------------------
// timestamp_rate_calibrator_core
// Calibrates timestamp ticks per microsecond against a down-counting
// reference timer, with retries and a fallback ratio.
// ----------------------------------------------------------------------------
// Timing: start and tracking samples report in the cycle after acceptance. A
// window-closing sample reports after load, 4 multiply-accumulate and 17 divide
// steps of the shared 89-bit unit; overflow stops at the first divide step.
// Throughput: one item per cycle while results drain; a closing sample holds
// off input until its result is taken.
// Reset (synchronous, active high): idle phase, registers at their defaults.
module timestamp_rate_calibrator_core
   import trc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // counter_value[15:0], timestamp[79:16],
                                    // load_pending[80], zero[87:81]
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // status[2:0], ticks_per_us[18:3],
                                    // attempt_index[22:19], reload_request[23]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   typedef enum logic [2:0] {
      P_IDLE  = 3'b001,
      P_WAIT  = 3'b010,
      P_TRACK = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      C_READY = 2'b01,
      C_CALC  = 2'b10
   } ctl_type;

   logic [15:0] wec_ff;
   logic [23:0] freq_ff;
   logic [15:0] min_ff;
   logic [15:0] max_ff;
   logic [3:0]  att_max_ff;
   logic [15:0] fb_ff;

   phase_type   phase_ff, phase_in;
   ctl_type     ctl_ff, ctl_in;
   logic [15:0] begin_count_ff, begin_count_in;
   logic [63:0] begin_time_ff, begin_time_in;
   logic [15:0] last_count_ff, last_count_in;
   logic [3:0]  attempt_ff, attempt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        req_fire;
   logic        func;
   logic [15:0] cnt;
   logic [63:0] ts;
   logic        pending;
   logic        last_try;
   logic        do_fail;
   status_type  fail_why;
   logic        do_emit;
   rsp_type     emit_rsp;
   logic        unit_start;
   logic [63:0] unit_delta;
   logic [15:0] unit_ticks;
   ratio_result_type unit_res;

   assign func     = req_tuser;
   assign cnt      = req_tdata[15:0];
   assign ts       = req_tdata[79:16];
   assign pending  = req_tdata[80];
   assign req_tready = (ctl_ff == C_READY) && (!rsp_valid_ff || rsp_tready);
   assign req_fire = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   // a limit of zero behaves as one
   assign last_try = ({1'b0, attempt_ff} + 5'd1) >= {1'b0, att_max_ff};

   trc_ratio_unit u_ratio (
      .clock  (clock),
      .reset  (reset),
      .start  (unit_start),
      .delta  (unit_delta),
      .freq   (freq_ff),
      .ticks  (unit_ticks),
      .result (unit_res)
   );

   always_comb begin
      phase_in       = phase_ff;
      ctl_in         = ctl_ff;
      begin_count_in = begin_count_ff;
      begin_time_in  = begin_time_ff;
      last_count_in  = last_count_ff;
      attempt_in     = attempt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_in         = rsp_ff;
      do_fail        = 1'b0;
      fail_why       = ST_WRAP;
      do_emit        = 1'b0;
      emit_rsp       = '{status: ST_ARMED, ratio: 16'd0, attempt: 4'd0, reload: 1'b1};
      unit_start     = 1'b0;
      unit_delta     = '0;
      unit_ticks     = '0;

      if (req_fire) begin
         if (!func) begin
            attempt_in = 4'd0;
            phase_in   = P_WAIT;
            do_emit    = 1'b1;
         end else begin
            unique case (phase_ff)
               P_WAIT: begin
                  if (!pending) begin
                     begin_count_in = cnt;
                     begin_time_in  = ts;
                     last_count_in  = cnt;
                     if (cnt <= wec_ff) begin
                        // closes at once: zero ticks, always implausible
                        unit_start = 1'b1;
                        ctl_in     = C_CALC;
                     end else begin
                        phase_in = P_TRACK;
                     end
                  end
               end
               P_TRACK: begin
                  if (cnt > last_count_ff) begin
                     do_fail  = 1'b1;
                     fail_why = ST_WRAP;
                  end else begin
                     last_count_in = cnt;
                     if (cnt <= wec_ff) begin
                        unit_start = 1'b1;
                        unit_delta = ts - begin_time_ff;
                        unit_ticks = begin_count_ff - cnt;
                        ctl_in     = C_CALC;
                     end
                  end
               end
               default: ;
            endcase
         end
      end

      if (ctl_ff == C_CALC && unit_res.done) begin
         ctl_in = C_READY;
         if (unit_res.ok && unit_res.ratio >= min_ff && unit_res.ratio <= max_ff) begin
            phase_in = P_IDLE;
            do_emit  = 1'b1;
            emit_rsp = '{status: ST_DONE, ratio: unit_res.ratio,
                         attempt: attempt_ff, reload: 1'b0};
         end else begin
            do_fail  = 1'b1;
            fail_why = ST_IMPL;
         end
      end

      if (do_fail) begin
         do_emit = 1'b1;
         if (last_try) begin
            phase_in = P_IDLE;
            emit_rsp = '{status: ST_FALLBACK, ratio: fb_ff,
                         attempt: attempt_ff, reload: 1'b0};
         end else begin
            attempt_in = attempt_ff + 4'd1;
            phase_in   = P_WAIT;
            emit_rsp   = '{status: fail_why, ratio: 16'd0,
                           attempt: attempt_ff, reload: 1'b1};
         end
      end

      if (do_emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wec_ff         <= 16'h1000;
         freq_ff        <= 24'd1193182;
         min_ff         <= 16'd100;
         max_ff         <= 16'd10000;
         att_max_ff     <= 4'd5;
         fb_ff          <= 16'd1000;
         phase_ff       <= P_IDLE;
         ctl_ff         <= C_READY;
         begin_count_ff <= '0;
         begin_time_ff  <= '0;
         last_count_ff  <= '0;
         attempt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_WINDOW_END: wec_ff     <= csr_data[15:0];
               CSR_REF_FREQ:   freq_ff    <= csr_data;
               CSR_MIN_RATIO:  min_ff     <= csr_data[15:0];
               CSR_MAX_RATIO:  max_ff     <= csr_data[15:0];
               CSR_MAX_ATT:    att_max_ff <= csr_data[3:0];
               CSR_FALLBACK:   fb_ff      <= csr_data[15:0];
               default: ;
            endcase
         end
         phase_ff       <= phase_in;
         ctl_ff         <= ctl_in;
         begin_count_ff <= begin_count_in;
         begin_time_ff  <= begin_time_in;
         last_count_ff  <= last_count_in;
         attempt_ff     <= attempt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.reload, rsp_ff.attempt, rsp_ff.ratio, rsp_ff.status};

endmodule

@@ tb/tb_timestamp_rate_calibrator_core.sv @@
// ----------------------------------------------------------------------------
// tb_timestamp_rate_calibrator_core
// Self-checking bench for the timestamp rate calibrator. A cycle-free model of
// the calibration state machine predicts the reports due from accepted items;
// a checker compares each report field by field, in order. Directed
// sequences cover idle samples, a clean window, wrap, zero ticks, overflow,
// re-arm, fallback and register masking. Random calibrations then run under
// several register settings, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb_timestamp_rate_calibrator_core;
   import trc_pkg::*;

   localparam logic       FUNC_START    = 1'b0;
   localparam logic       FUNC_SAMPLE   = 1'b1;
   localparam logic [2:0] CSR_UNUSED    = 3'd7;
   localparam int         SETTLE_CYCLES = 40;     // covers a closing divide
   localparam int         STALL_LIMIT   = 2000;
   localparam int         RANDOM_ITEMS  = 880;
   localparam int         SETTING_SPAN  = 110;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT,
      PH_TRACK
   } calib_phase_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = '0;
   logic [23:0] csr_data   = '0;

   // register copies
   logic [15:0] win_end   = 16'h1000;
   logic [23:0] ref_hz    = 24'd1193182;
   logic [15:0] lo_ratio  = 16'd100;
   logic [15:0] hi_ratio  = 16'd10000;
   logic [3:0]  att_limit = 4'd5;
   logic [15:0] fb_ratio  = 16'd1000;

   // calibration state copy
   calib_phase_type cal_phase  = PH_IDLE;
   logic [15:0]     begin_cnt  = '0;
   logic [63:0]     begin_ts   = '0;
   logic [15:0]     last_cnt   = '0;
   logic [3:0]      attempt_no = '0;

   rsp_type     due_reports[$];
   int unsigned fail_count = 0;
   int unsigned items_sent = 0;
   int          rsp_hold   = 0;
   bit          gaps_on    = 1'b1;

   always #6 clock = ~clock;

   timestamp_rate_calibrator_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   function automatic void queue_report(status_type st, logic [15:0] ratio,
                                        logic [3:0] att, logic rl);
      rsp_type r;
      r.status  = st;
      r.ratio   = ratio;
      r.attempt = att;
      r.reload  = rl;
      due_reports.push_back(r);
   endfunction

   function automatic void end_attempt(status_type why);
      if ({1'b0, attempt_no} + 5'd1 >= {1'b0, att_limit}) begin
         cal_phase = PH_IDLE;
         queue_report(ST_FALLBACK, fb_ratio, attempt_no, 1'b0);
      end else begin
         queue_report(why, 16'd0, attempt_no, 1'b1);
         attempt_no = attempt_no + 4'd1;
         cal_phase  = PH_WAIT;
      end
   endfunction

   function automatic void close_window(logic [63:0] now);
      logic [15:0]  ticks;
      logic [63:0]  delta;
      logic [127:0] quot;
      ticks = begin_cnt - last_cnt;
      delta = now - begin_ts;
      quot  = '1;
      if (ticks != 16'd0)
         quot = (128'(delta) * 128'(ref_hz)) / (128'(ticks) * 128'(US_PER_S));
      if (quot <= 128'hFFFF && quot[15:0] >= lo_ratio && quot[15:0] <= hi_ratio) begin
         cal_phase = PH_IDLE;
         queue_report(ST_DONE, quot[15:0], attempt_no, 1'b0);
      end else begin
         end_attempt(ST_IMPL);
      end
   endfunction

   function automatic void advance_calibration(logic func, logic [15:0] cnt,
                                               logic [63:0] ts, logic pend);
      if (func == FUNC_START) begin
         attempt_no = 4'd0;
         cal_phase  = PH_WAIT;
         queue_report(ST_ARMED, 16'd0, 4'd0, 1'b1);
      end else begin
         case (cal_phase)
            PH_WAIT: begin
               if (!pend) begin
                  begin_cnt = cnt;
                  begin_ts  = ts;
                  last_cnt  = cnt;
                  if (cnt <= win_end) close_window(ts);
                  else cal_phase = PH_TRACK;
               end
            end
            PH_TRACK: begin
               if (cnt > last_cnt) begin
                  end_attempt(ST_WRAP);
               end else begin
                  last_cnt = cnt;
                  if (cnt <= win_end) close_window(ts);
               end
            end
            default: ;
         endcase
      end
   endfunction

   // timestamp span that gives about `goal` ticks per us over `ticks` counts
   function automatic logic [63:0] span_for(logic [31:0] goal, logic [15:0] ticks);
      logic [127:0] num;
      num = 128'(goal) * 128'(ticks) * 128'(US_PER_S);
      return 64'((num + 128'(ref_hz) - 128'd1) / 128'(ref_hz));
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // mostly short, now and then long
   function automatic int idle_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(15, 60);
      return $urandom_range(1, 3);
   endfunction

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   // valid stays high when no gap follows; the next caller takes over
   task automatic send_item(input logic func, input logic [15:0] cnt,
                            input logic [63:0] ts, input logic pend);
      int gap;
      req_tuser  <= func;
      req_tdata  <= {7'd0, pend, ts, cnt};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      advance_calibration(func, cnt, ts, pend);
      gap = (gaps_on && $urandom_range(0, 1) == 0) ? idle_len() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic await_idle();
      req_tvalid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WINDOW_END: win_end   = value[15:0];
         CSR_REF_FREQ:   ref_hz    = value;
         CSR_MIN_RATIO:  lo_ratio  = value[15:0];
         CSR_MAX_RATIO:  hi_ratio  = value[15:0];
         CSR_MAX_ATT:    att_limit = value[3:0];
         CSR_FALLBACK:   fb_ratio  = value[15:0];
         default: ;
      endcase
   endtask

   task automatic load_setting(input logic [23:0] w, input logic [23:0] hz,
                               input logic [23:0] lo, input logic [23:0] hi,
                               input logic [23:0] att, input logic [23:0] fb);
      await_idle();
      write_reg(CSR_WINDOW_END, w);
      write_reg(CSR_REF_FREQ, hz);
      write_reg(CSR_MIN_RATIO, lo);
      write_reg(CSR_MAX_RATIO, hi);
      write_reg(CSR_MAX_ATT, att);
      write_reg(CSR_FALLBACK, fb);
      write_reg(CSR_UNUSED, 24'($urandom));
      csr_valid <= 1'b0;
   endtask

   // one attempt from the waiting phase: pending samples, begin point,
   // tracking, then a wrap, a re-arm or the closing sample
   task automatic play_attempt();
      logic [15:0] top, level, cnt;
      logic [63:0] t0;
      logic [31:0] goal, a, b;
      repeat ($urandom_range(0, 2)) send_item(FUNC_SAMPLE, 16'($urandom), rand64(), 1'b1);
      if (win_end == 16'hFFFF || $urandom_range(0, 11) == 0)
         top = 16'($urandom);
      else if ($urandom_range(0, 3) == 0)
         top = FULL_COUNT;
      else
         top = 16'($urandom_range(win_end + 1, 16'hFFFF));
      t0 = rand64();
      send_item(FUNC_SAMPLE, top, t0, 1'b0);
      if (cal_phase != PH_TRACK) return;
      level = top;
      repeat ($urandom_range(0, 4)) begin
         if ($urandom_range(0, 39) == 0) begin
            send_item(FUNC_START, 16'($urandom), rand64(), 1'($urandom));
            return;
         end
         if (level != 16'hFFFF && $urandom_range(0, 24) == 0) begin
            send_item(FUNC_SAMPLE, 16'($urandom_range(level + 1, 16'hFFFF)), rand64(),
                      1'($urandom));
            return;
         end
         level = 16'($urandom_range(win_end + 1, level));
         send_item(FUNC_SAMPLE, level, rand64(), 1'($urandom));
      end
      cnt = ($urandom_range(0, 4) == 0) ? win_end : 16'($urandom_range(0, win_end));
      a = (lo_ratio <= hi_ratio) ? lo_ratio : hi_ratio;
      b = (lo_ratio <= hi_ratio) ? hi_ratio : lo_ratio;
      case ($urandom_range(0, 9))
         0: goal = lo_ratio;
         1: goal = hi_ratio;
         2: goal = (lo_ratio == 16'd0) ? 32'd0 : lo_ratio - 32'd1;
         3: goal = hi_ratio + 32'd1;
         4: goal = $urandom_range(65536, 400000);
         default: goal = $urandom_range(a, b);
      endcase
      send_item(FUNC_SAMPLE, cnt, t0 + span_for(goal, top - cnt) + 64'($urandom_range(0, 2)),
                1'($urandom));
   endtask

   task automatic run_calibration();
      send_item(FUNC_START, 16'($urandom), rand64(), 1'($urandom));
      while (cal_phase != PH_IDLE) play_attempt();
   endtask

   task automatic apply_setting(input int which);
      logic [15:0] lo, hi;
      case (which)
         0: load_setting(24'h0000, 24'hFFFFFF, 24'd0, 24'hFFFF, 24'd15, 24'hFFFF);
         1: load_setting(24'hFFFF, 24'd1, 24'd1, 24'd1, 24'd1, 24'd0);
         2: load_setting(24'h1000, 24'd1193182, 24'd100, 24'd10000, 24'd5, 24'd1000);
         default: begin
            lo = 16'($urandom_range(0, 3000));
            hi = lo + 16'($urandom_range(0, 20000));
            if ($urandom_range(0, 7) == 0) {lo, hi} = {hi, lo};
            load_setting({8'($urandom), 16'($urandom_range(0, 16'h9000))},
                         24'($urandom_range(1, 24'hFFFFFF)),
                         {8'($urandom), lo}, {8'($urandom), hi},
                         {20'($urandom), 4'($urandom_range(1, 15))},
                         {8'($urandom), 16'($urandom)});
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_idle_samples();
      send_item(FUNC_SAMPLE, 16'hFFFF, '1, 1'b1);
      send_item(FUNC_SAMPLE, 16'h0000, '0, 1'b0);
   endtask

   task automatic test_good_window();
      send_item(FUNC_START, 16'h0000, '0, 1'b0);
      send_item(FUNC_SAMPLE, 16'h1234, rand64(), 1'b1);   // reload not in yet
      send_item(FUNC_SAMPLE, FULL_COUNT, '1, 1'b0);       // timestamp wraps in window
      send_item(FUNC_SAMPLE, 16'h8000, rand64(), 1'b1);   // flag ignored while tracking
      send_item(FUNC_SAMPLE, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF + span_for(1000, FULL_COUNT),
                1'b0);
   endtask

   task automatic test_retry_paths();
      logic [63:0] t0;
      send_item(FUNC_START, 16'hFFFF, '1, 1'b1);
      send_item(FUNC_SAMPLE, 16'h9000, '0, 1'b0);
      send_item(FUNC_SAMPLE, 16'h9001, rand64(), 1'b0);   // count rose
      send_item(FUNC_SAMPLE, win_end, rand64(), 1'b0);    // zero ticks
      t0 = rand64();
      send_item(FUNC_SAMPLE, FULL_COUNT, t0, 1'b0);
      send_item(FUNC_SAMPLE, 16'h0FFF, t0 + span_for(32'd70000, FULL_COUNT - 16'h0FFF), 1'b0);
      send_item(FUNC_SAMPLE, FULL_COUNT, rand64(), 1'b0);
      send_item(FUNC_START, 16'h0000, rand64(), 1'b0);    // re-arm while tracking
   endtask

   task automatic test_fallback();
      logic [63:0] t0;
      load_setting(24'h1000, 24'd1193182, 24'd100, 24'd10000, 24'd1, 24'd1000);
      send_item(FUNC_START, 16'h0000, '0, 1'b0);
      send_item(FUNC_SAMPLE, 16'h0000, rand64(), 1'b0);
      // attempt limit written as zero after masking
      load_setting(24'hAB1000, 24'd1193182, 24'hFF0064, 24'h0F2710, 24'hFFFFF0, 24'h12FFFF);
      send_item(FUNC_START, 16'h0000, '0, 1'b0);
      send_item(FUNC_SAMPLE, 16'h0100, rand64(), 1'b0);
      // empty plausible range
      load_setting(24'h1000, 24'd1193182, 24'd500, 24'd400, 24'd2, 24'd0);
      t0 = rand64();
      send_item(FUNC_START, 16'h0000, '0, 1'b0);
      send_item(FUNC_SAMPLE, FULL_COUNT, t0, 1'b0);
      send_item(FUNC_SAMPLE, 16'h0000, t0 + span_for(450, FULL_COUNT), 1'b0);
      send_item(FUNC_SAMPLE, 16'h0000, rand64(), 1'b0);
   endtask

   task automatic test_backpressure();
      await_idle();
      gaps_on  = 1'b0;
      rsp_hold = 250;
      // start offering only once the receiver has begun its hold
      while (rsp_hold != 0) @(posedge clock);
      repeat (12) send_item(FUNC_START, 16'($urandom), rand64(), 1'($urandom));
      await_idle();
      gaps_on = 1'b1;
   endtask

   task automatic test_random_calibrations();
      int stop_at, next_switch, setting;
      stop_at     = items_sent + RANDOM_ITEMS;
      next_switch = items_sent;
      setting     = 0;
      while (items_sent < stop_at) begin
         if (items_sent >= next_switch) begin
            apply_setting(setting);
            setting++;
            next_switch = items_sent + SETTING_SPAN;
            gaps_on     = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 4))
               send_item(1'($urandom), 16'($urandom), rand64(), 1'($urandom));
         else
            run_calibration();
      end
   endtask

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------
   initial begin : rsp_side
      int n;
      @(posedge clock);
      forever begin
         if (rsp_hold != 0) begin
            n          = rsp_hold;
            rsp_hold   = 0;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            n          = idle_len();
            rsp_tready <= 1'b0;
         end else begin
            n          = $urandom_range(1, 40);
            rsp_tready <= 1'b1;
         end
         repeat (n) @(posedge clock);
      end
   end

   always @(posedge clock) begin : report_check
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_reports.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected report %h", rsp_tdata);
         end else begin
            want = due_reports.pop_front();
            if (rsp_tdata[2:0] !== want.status || rsp_tdata[18:3] !== want.ratio ||
                rsp_tdata[22:19] !== want.attempt || rsp_tdata[23] !== want.reload) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("report mismatch: expected status %0d ratio %0d attempt %0d %s",
                           want.status, want.ratio, want.attempt,
                           $sformatf("reload %0d, got status %0d ratio %0d attempt %0d reload %0d",
                                     want.reload, rsp_tdata[2:0], rsp_tdata[18:3],
                                     rsp_tdata[22:19], rsp_tdata[23]));
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_idle_samples();
      test_good_window();
      test_retry_paths();
      test_fallback();
      test_backpressure();
      test_random_calibrations();
      await_idle();
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ sim.f @@
design/trc_pkg.sv
design/trc_ratio_unit.sv
design/timestamp_rate_calibrator_core.sv
tb/tb_timestamp_rate_calibrator_core.sv
